>>> sv/bitmap_page_frame_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap page frame allocator
// Implication checks sampled on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_SAME(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("bpfa assertion failed");

// next-cycle implication
`define BPFA_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("bpfa assertion failed");

`endif

>>> sv/bpfa_pkg.sv
// ---------------------------------------------------------------------------
// bpfa_pkg
// Shared constants and types of the bitmap page frame allocator.
// ---------------------------------------------------------------------------
package bpfa_pkg;

  localparam int FRAMES_DEF    = 65536;
  localparam int WORD_BITS_DEF = 32;
  localparam int PAGE_SHIFT    = 12;
  localparam int ADDR_W        = 32;
  localparam int CNT_W         = 17;   // free count, frame_count, frame_limit
  localparam int FRM_W         = 21;   // frame numbers, range ends and limits
  localparam int PFN_W         = ADDR_W - PAGE_SHIFT;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_RESERVE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_DBLFREE = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RANGE = 2'd1,
    OP_COUNT = 2'd2
  } op_t;

  // classified request, front to back
  typedef struct packed {
    op_t              op;
    logic             set;     // range sets used bits
    logic             single;  // single-frame free
    logic             st_lim;  // part of the request lies at or above the limit
    logic [FRM_W-1:0] lo;
    logic [FRM_W-1:0] hi;
  } req_t;

endpackage

>>> sv/bitmap_page_frame_allocator.sv
// Allocate: each bitmap word is read (S_RD), then tested and updated (S_OP), up to the first free frame,
//   then S_DONE; range requests likewise per word touched; empty or refused requests go straight to S_DONE.
// Throughput: one item at a time in the word engine; a 2-entry queue and output register
//   decouple input and output. The single-port bitmap RAM read-modify-write sets the pace.
// Reset: a clearing pass over every bitmap word marks every frame used, no item taken;
//   a frame_limit write recounts free frames, reading each word below the limit.
// ---------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a used-bit map with exact free count.
// ---------------------------------------------------------------------------
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [55:0]      s_tdata,   // address[31:0], frame_count[48:32], zeros
  input  logic [1:0]       s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata,   // frame_address[31:0], free_frames[48:32], zeros
  output logic [1:0]       m_tuser    // status[1:0]
);

  logic [CNT_W-1:0]  frame_limit;
  logic [FRM_W-1:0]  lim;
  logic              clearing;
  logic              q_valid;
  req_t              q_item;
  logic              q_pop;
  logic [ADDR_W-1:0] faddr;
  logic [CNT_W-1:0]  free_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= CNT_W'(65536);
    end else if (cfg_we) begin
      frame_limit <= cfg_wdata;
    end
  end

  assign lim = (FRM_W'(frame_limit) > FRM_W'(FRAMES)) ? FRM_W'(FRAMES) : FRM_W'(frame_limit);

  bpfa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .lim      (lim),
    .hold     (clearing),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_type  (s_tuser),
    .in_addr  (s_tdata[31:0]),
    .in_count (s_tdata[48:32]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bpfa_back #(
    .FRAMES    (FRAMES),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .lim         (lim),
    .recount_req (cfg_we),
    .clearing    (clearing),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (m_tuser),
    .out_faddr   (faddr),
    .out_free    (free_out)
  );

  assign m_tdata = {7'd0, free_out, faddr};

endmodule

>>> sv/bpfa_front.sv
// ---------------------------------------------------------------------------
// bpfa_front
// Accepts request items, turns each into a frame range and queues it.
// ---------------------------------------------------------------------------
module bpfa_front
  import bpfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [FRM_W-1:0] lim,
  input  logic             hold,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_type,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [CNT_W-1:0] in_count,
  output logic             q_valid,
  output req_t             q_item,
  input  logic             q_pop
);

  req_t             cls;
  logic [FRM_W-1:0] f;
  logic [FRM_W-1:0] fend;
  req_t             q0;
  req_t             q1;
  logic [1:0]       fill;
  logic             push;

  always_comb begin
    f    = FRM_W'(in_addr[ADDR_W-1:PAGE_SHIFT]);
    fend = f + FRM_W'(in_count);
    cls  = '0;
    unique case (in_type)
      REQ_ALLOC: begin
        cls.op = OP_ALLOC;
        cls.lo = '0;
        cls.hi = lim;
      end
      REQ_FREE: begin
        cls.op     = OP_RANGE;
        cls.single = 1'b1;
        cls.st_lim = (f >= lim);
        cls.lo     = f;
        cls.hi     = (f >= lim) ? f : f + FRM_W'(1);
      end
      default: begin
        cls.op     = OP_RANGE;
        cls.set    = (in_type == REQ_RESERVE);
        cls.st_lim = (in_count != '0) && (fend > lim);
        cls.lo     = f;
        cls.hi     = (fend < lim) ? fend : lim;
      end
    endcase
  end

  assign in_ready = (fill != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // two-entry queue, head in q0
  always_ff @(posedge clk) begin
    if (q_pop) begin
      q0 <= (push && fill == 2'd1) ? cls : q1;
      if (push && fill == 2'd2) q1 <= cls;
    end else if (push) begin
      if (fill == 2'd0) q0 <= cls;
      else q1 <= cls;
    end
  end

endmodule

>>> sv/bpfa_back.sv
// ---------------------------------------------------------------------------
// bpfa_back
// Bitmap memory and the word engine: clear, recount, first-fit, ranges.
// ---------------------------------------------------------------------------
module bpfa_back
  import bpfa_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic [FRM_W-1:0]  lim,
  input  logic              recount_req,
  output logic              clearing,
  input  logic              q_valid,
  input  req_t              q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_faddr,
  output logic [CNT_W-1:0]  out_free
);

  `include "bitmap_page_frame_allocator_assert.svh"

  localparam int NWORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WI     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BS     = $clog2(WORD_BITS);
  localparam int BW     = (BS > 0) ? BS : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_OP    = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                 state;
  logic [WORD_BITS-1:0]   mem [NWORDS];
  logic [WORD_BITS-1:0]   rdata;
  logic                   mem_we;
  logic [WORD_BITS-1:0]   wdata;
  logic [WI-1:0]          widx;
  logic [WI-1:0]          last;
  req_t                   cur;
  logic                   pend;
  logic [CNT_W-1:0]       free_total;
  logic [1:0]             res_status;
  logic [ADDR_W-1:0]      res_faddr;
  logic                   out_load;

  logic [FRM_W-1:0]       base;
  logic [WORD_BITS-1:0]   m;
  logic [WORD_BITS-1:0]   avail;
  logic [WORD_BITS-1:0]   chg;
  logic [BW-1:0]          pick;
  logic [CNT_W-1:0]       nchg;
  logic [CNT_W-1:0]       nfree;
  logic [FRM_W-1:0]       fidx;

  function automatic logic [WORD_BITS-1:0] below(logic [FRM_W-1:0] n,
                                                 logic [FRM_W-1:0] b);
    logic [FRM_W-1:0]     d;
    logic [WORD_BITS-1:0] r;
    d = n - b;
    if (n <= b) r = '0;
    else if (d >= FRM_W'(WORD_BITS)) r = '1;
    else r = ~({WORD_BITS{1'b1}} << d[BW:0]);
    return r;
  endfunction

  always_comb begin
    base  = FRM_W'(widx) << BS;
    m     = below(cur.hi, base) & ~below(cur.lo, base);
    avail = ~rdata & m;
    chg   = m & (cur.set ? ~rdata : rdata);
    pick  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) pick = BW'(i);
    end
    nchg  = CNT_W'($countones(chg));
    nfree = CNT_W'($countones(avail));
    fidx  = base + FRM_W'(pick);
  end

  assign clearing = (state == S_CLEAR);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign q_pop    = (state == S_IDLE) && !pend && q_valid;

  always_comb begin
    mem_we = 1'b0;
    wdata  = '1;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_OP) begin
      if (cur.op == OP_ALLOC) begin
        mem_we = (avail != '0);
        wdata  = rdata | (WORD_BITS'(1) << pick);
      end else if (cur.op == OP_RANGE) begin
        mem_we = 1'b1;
        wdata  = rdata ^ chg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[widx] <= wdata;
    rdata <= mem[widx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      widx       <= '0;
      pend       <= 1'b0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (recount_req) pend <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          widx <= widx + WI'(1);
          if (widx == WI'(NWORDS - 1)) begin
            widx  <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pend) begin
            pend       <= recount_req;
            free_total <= '0;
            cur.op     <= OP_COUNT;
            cur.set    <= 1'b0;
            cur.lo     <= '0;
            cur.hi     <= lim;
            widx       <= '0;
            last       <= WI'((lim - FRM_W'(1)) >> BS);
            if (lim != '0) state <= S_RD;
          end else if (q_valid) begin
            cur       <= q_item;
            res_faddr <= '0;
            widx      <= q_item.lo[BS +: WI];
            last      <= WI'((q_item.hi - FRM_W'(1)) >> BS);
            if (q_item.lo < q_item.hi) begin
              state <= S_RD;
            end else begin
              // nothing to touch: answer at once
              if (q_item.op == OP_ALLOC) res_status <= ST_NOMEM;
              else if (q_item.st_lim) res_status <= ST_LIMIT;
              else res_status <= ST_OK;
              state <= S_DONE;
            end
          end
        end
        S_RD: begin
          state <= S_OP;
        end
        S_OP: begin
          unique case (cur.op)
            OP_ALLOC: begin
              if (avail != '0) begin
                free_total <= free_total - CNT_W'(1);
                res_faddr  <= ADDR_W'(fidx) << PAGE_SHIFT;
                res_status <= ST_OK;
                state      <= S_DONE;
              end else if (widx == last) begin
                res_status <= ST_NOMEM;
                state      <= S_DONE;
              end else begin
                widx  <= widx + WI'(1);
                state <= S_RD;
              end
            end
            OP_RANGE: begin
              if (cur.set) free_total <= free_total - nchg;
              else free_total <= free_total + nchg;
              if (widx == last) begin
                if (cur.single && chg == '0) res_status <= ST_DBLFREE;
                else if (cur.st_lim) res_status <= ST_LIMIT;
                else res_status <= ST_OK;
                state <= S_DONE;
              end else begin
                widx  <= widx + WI'(1);
                state <= S_RD;
              end
            end
            default: begin
              free_total <= free_total + nfree;
              if (widx == last) begin
                state <= S_IDLE;
              end else begin
                widx  <= widx + WI'(1);
                state <= S_RD;
              end
            end
          endcase
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_faddr  <= res_faddr;
      out_free   <= free_total;
    end
  end

  `BPFA_ASSERT_SAME(a_we_state, mem_we, (state == S_CLEAR) || (state == S_OP))
  `BPFA_ASSERT_SAME(a_no_out_clear, state == S_CLEAR, !out_valid && !q_pop)
  `BPFA_ASSERT_NEXT(a_load_valid, out_load, out_valid)
  `BPFA_ASSERT_SAME(a_pop_idle, q_pop, (state == S_IDLE) && q_valid)

endmodule
